FILE: rtl/olmf_pkg.sv
// ----------------------------------------------------------------------------
// olmf_pkg
// Shared types and constants for the opcode/length message framer.
// ----------------------------------------------------------------------------
package olmf_pkg;

  // Byte field masks and the good checksum value
  localparam logic [7:0] OPC_FLAG   = 8'h80;
  localparam logic [7:0] LEN_FIELD  = 8'h60;
  localparam logic [7:0] CHK_GOOD   = 8'hFF;

  // Opcode length code that defers the length to the second byte
  localparam logic [1:0] LEN_CARRIED = 2'd3;

  // Default message buffer depth
  localparam int MAX_MESSAGE_DEF = 64;

  // Widths fixed by the channel payload
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 6;
  localparam int LEN_W  = 7;

  // Framer control state
  typedef enum logic {
    S_COLLECT,
    S_DRAIN
  } olmf_state_t;

endpackage

FILE: rtl/olmf_if.sv
// ----------------------------------------------------------------------------
// olmf_if
// Valid/ready channels of the framer: received bytes in, message bytes out.
// ----------------------------------------------------------------------------
interface olmf_rx_if
  import olmf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface olmf_msg_if
  import olmf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] msg_byte;
  logic [IDX_W-1:0]  byte_index;
  logic              last_of_message;

  modport source (output valid, output msg_byte, output byte_index,
                  output last_of_message, input ready);
  modport sink   (input valid, input msg_byte, input byte_index,
                  input last_of_message, output ready);
endinterface

FILE: rtl/opcode_length_message_framer_unit.sv
// ----------------------------------------------------------------------------
// opcode_length_message_framer_unit
// Rebuilds opcode/length framed messages from a byte stream, checks the XOR
// checksum and replays good messages from the message buffer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one received byte per transaction. A byte with bit 7 set opens a
//            message; data bytes outside a message are dropped.
//   out_ch : one transaction per byte of a good message, opcode first, with
//            byte_index counting from 0 and last_of_message on the checksum.
// Timing:
//   The byte that completes a good n-byte message is followed by a replay of n
//   bytes read from the buffer at one byte per cycle while out_ch.ready stays
//   high; each byte passes the registered read (mem_q_r) and then the output
//   register, and in_ch is ready again once the last read has moved into the
//   output register.
//   Buffer writes happen only while collecting and reads only while
//   replaying, so the two never touch the same entry in the same cycle.
// Reset (rst_n low, synchronous): no message open, output empty; buffer
//   contents are left as they are.
// Stall: when out_ch.ready is low the output register and the pending read
//   hold; the replay simply pauses and in_ch stays not ready until it ends.
// ----------------------------------------------------------------------------
module opcode_length_message_framer_unit
  import olmf_pkg::*;
#(
  parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  olmf_rx_if.sink     in_ch,
  olmf_msg_if.source  out_ch
);

  localparam int AW = $clog2(MAX_MESSAGE);
  localparam int CW = $clog2(MAX_MESSAGE + 1);
  localparam int LW = (CW > LEN_W) ? CW : LEN_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_MESSAGE);

  // Message buffer
  logic [BYTE_W-1:0] msg_mem [MAX_MESSAGE];
  logic [BYTE_W-1:0] mem_q_r;

  // Collect state
  olmf_state_t       state_r, state_nxt;
  logic              in_msg_r, in_msg_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  exp_r, exp_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic [1:0]        sel_r, sel_nxt;

  // Replay state
  logic [CW-1:0]     drain_len_r, drain_len_nxt;
  logic [CW-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  pend_idx_r;
  logic              pend_last_r;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_last_r;

  // Datapath terms
  logic              acc;
  logic              is_opc;
  logic              data_ok;
  logic [CW-1:0]     cnt_inc;
  logic [BYTE_W-1:0] xor_inc;
  logic [LEN_W-1:0]  exp_inc;
  logic [LW-1:0]     cnt_cmp;
  logic [LW-1:0]     exp_cmp;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic              load_out;
  logic              rd_last;

  assign in_ch.ready = (state_r == S_COLLECT);
  assign acc         = in_ch.valid && in_ch.ready;
  assign is_opc      = (in_ch.rx_byte & OPC_FLAG) != '0;
  assign data_ok     = in_msg_r && (cnt_r < MAX_CNT);

  // Next values for a data byte
  assign cnt_inc = cnt_r + CW'(1);
  assign xor_inc = xor_r ^ in_ch.rx_byte;
  assign exp_inc = (cnt_inc == CW'(2) && sel_r == LEN_CARRIED) ?
                   in_ch.rx_byte[LEN_W-1:0] : exp_r;
  assign cnt_cmp = LW'(cnt_inc);
  assign exp_cmp = LW'(exp_inc);

  // Buffer write: opcode at entry 0, data bytes at the current count
  assign wr_en   = acc && (is_opc || data_ok);
  assign wr_addr = is_opc ? '0 : cnt_r[AW-1:0];

  // Replay read scheduling: one read may wait in mem_q_r
  assign load_out = pend_r && (!out_valid_r || out_ch.ready);
  assign rd_en    = (state_r == S_DRAIN) && (rd_cnt_r < drain_len_r) &&
                    (!pend_r || load_out);
  assign rd_last  = (rd_cnt_r + CW'(1)) == drain_len_r;

  // Collect / replay control
  always_comb begin
    state_nxt     = state_r;
    in_msg_nxt    = in_msg_r;
    cnt_nxt       = cnt_r;
    exp_nxt       = exp_r;
    xor_nxt       = xor_r;
    sel_nxt       = sel_r;
    drain_len_nxt = drain_len_r;
    rd_cnt_nxt    = rd_cnt_r;

    case (state_r)
      S_COLLECT: begin
        if (acc) begin
          if (is_opc) begin
            in_msg_nxt = 1'b1;
            cnt_nxt    = CW'(1);
            xor_nxt    = in_ch.rx_byte;
            sel_nxt    = in_ch.rx_byte[6:5];
            exp_nxt    = (in_ch.rx_byte[6:5] == LEN_CARRIED) ? '0 :
                         LEN_W'({in_ch.rx_byte[6:5], 1'b0}) + LEN_W'(2);
          end else if (in_msg_r) begin
            // Default: close the message; overwritten when it stays open
            in_msg_nxt = 1'b0;
            cnt_nxt    = '0;
            exp_nxt    = '0;
            xor_nxt    = '0;
            if (data_ok && exp_inc != '0 && cnt_cmp < exp_cmp) begin
              in_msg_nxt = 1'b1;
              cnt_nxt    = cnt_inc;
              exp_nxt    = exp_inc;
              xor_nxt    = xor_inc;
            end else if (data_ok && exp_inc != '0 && cnt_cmp == exp_cmp &&
                         xor_inc == CHK_GOOD) begin
              state_nxt     = S_DRAIN;
              drain_len_nxt = cnt_inc;
              rd_cnt_nxt    = '0;
            end
          end
        end
      end
      S_DRAIN: begin
        if (rd_en) begin
          rd_cnt_nxt = rd_cnt_r + CW'(1);
        end
        if (load_out && pend_last_r) begin
          state_nxt = S_COLLECT;
        end
      end
      default: begin
        state_nxt = S_COLLECT;
      end
    endcase
  end

  // Pending read and output register occupancy
  always_comb begin
    pend_nxt = pend_r;
    if (rd_en) begin
      pend_nxt = 1'b1;
    end else if (load_out) begin
      pend_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      in_msg_r    <= 1'b0;
      cnt_r       <= '0;
      exp_r       <= '0;
      xor_r       <= '0;
      sel_r       <= '0;
      drain_len_r <= '0;
      rd_cnt_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_msg_r    <= in_msg_nxt;
      cnt_r       <= cnt_nxt;
      exp_r       <= exp_nxt;
      xor_r       <= xor_nxt;
      sel_r       <= sel_nxt;
      drain_len_r <= drain_len_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Message buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      msg_mem[wr_addr] <= in_ch.rx_byte;
    end
    if (rd_en) begin
      mem_q_r <= msg_mem[rd_cnt_r[AW-1:0]];
    end
  end

  // Tags that travel with the pending read, and the output payload
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_idx_r  <= IDX_W'(rd_cnt_r);
      pend_last_r <= rd_last;
    end
    if (load_out) begin
      out_byte_r <= mem_q_r;
      out_idx_r  <= pend_idx_r;
      out_last_r <= pend_last_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.msg_byte        = out_byte_r;
  assign out_ch.byte_index      = out_idx_r;
  assign out_ch.last_of_message = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("byte count beyond buffer depth");

  a_closed_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !in_msg_r |-> (cnt_r == '0 && xor_r == '0 && exp_r == '0))
    else $error("closed message left state behind");

  a_drain_good_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COLLECT && state_nxt == S_DRAIN) |-> (xor_inc == CHK_GOOD))
    else $error("replay started on a bad checksum");

  a_pend_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == S_DRAIN)
    else $error("buffer read pending outside replay");

  a_out_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DRAIN))
    else $error("result appeared outside replay");

  a_drain_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && state_nxt == S_COLLECT) |=> (out_valid_r && out_last_r))
    else $error("replay ended without a final byte");

endmodule
